// ===== hdl/aes_block_cipher_core_defines.svh =====
// Assertion macros for the AES block cipher core.
// Used by the top level; depends on nothing.
`ifndef AES_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES_BLOCK_CIPHER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AES_ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aes core check failed");
`define AES_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("aes core forbidden condition");
`else
`define AES_ASSERT_IMPL(lbl, prop)
`define AES_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== hdl/aes_pkg.sv =====
// Shared types, S-box tables and round functions for the AES core.
// No dependencies.
package aes_pkg;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  typedef struct packed {
    logic exp_clear;
    logic exp_step;
    logic load;
    logic round_step;
  } aes_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic exp_last;
    logic round_last;
  } aes_status_t;

  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;

  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;

  localparam logic [0:3][7:0] MIX_FWD = {8'h02, 8'h03, 8'h01, 8'h01};
  localparam logic [0:3][7:0] MIX_INV = {8'h0E, 8'h0B, 8'h0D, 8'h09};

  localparam logic [0:255][7:0] FWD_SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc = acc ^ a;
      a = xtime(a);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Byte k of the state sits at bits 127-8k downto 120-8k; byte = col*4 + row.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [1:0] from;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        from = inv ? 2'(c + 4 - r) : 2'(c + r);
        t[127 - 8 * (c * 4 + r) -: 8] = s[127 - 8 * (int'(from) * 4 + r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int k = 0; k < 16; k++) begin
      t[127 - 8 * k -: 8] = inv ? INV_SBOX[s[127 - 8 * k -: 8]] : FWD_SBOX[s[127 - 8 * k -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] acc;
    logic [1:0] k;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) begin
          k = 2'(j + 4 - r);
          acc = acc ^ gf_mul(s[127 - 8 * (c * 4 + j) -: 8], inv ? MIX_INV[k] : MIX_FWD[k]);
        end
        t[127 - 8 * (c * 4 + r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [127:0] t;
    t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
    if (mix) t = mix_columns(t, 1'b0);
    return t ^ rk;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [127:0] t;
    t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ rk;
    if (mix) t = mix_columns(t, 1'b1);
    return t;
  endfunction

endpackage

// ===== hdl/aes_ctrl.sv =====
// Sequencer for the AES core: key expansion, block load, rounds, result beat.
// Depends on aes_pkg.
module aes_ctrl import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  aes_status_t status,
  output aes_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  aes_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_EXPAND;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    if (status.cfg_hit) begin
      // key registers changed: rebuild the schedule
      cmd.exp_clear = 1'b1;
      state_next = ST_EXPAND;
    end else begin
      case (state)
        ST_EXPAND: begin
          cmd.exp_step = 1'b1;
          if (status.exp_last) state_next = ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            cmd.load = 1'b1;
            state_next = ST_ROUND;
          end
        end
        ST_ROUND: begin
          cmd.round_step = 1'b1;
          if (status.round_last) state_next = ST_DONE;
        end
        ST_DONE: state_next = ST_IDLE;
        default: state_next = ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

// ===== hdl/aes_datapath.sv =====
// Key registers, key expansion, round-key store and round unit of the AES core.
// Depends on aes_pkg.
module aes_datapath import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         func,
  input  logic [63:0]  block_high,
  input  logic [63:0]  block_low,
  input  aes_cmd_t     cmd,
  output aes_status_t  status,
  output logic [63:0]  out_high,
  output logic [63:0]  out_low
);

  logic [1:0]  key_length;
  logic [63:0] key_word [4];

  logic [127:0] rk_row [15];
  logic [31:0]  win [8];
  logic [5:0]   exp_idx;
  logic [2:0]   exp_mod;
  logic [7:0]   rcon;

  logic [127:0] st;
  logic         dir;
  logic [3:0]   rnd;

  logic [3:0]   nk;
  logic [2:0]   nk_m1;
  logic [5:0]   total_m1;
  logic [3:0]   nr;
  logic [31:0]  new_word;
  logic [31:0]  t;
  logic [63:0]  src;
  logic [3:0]   rk_addr;
  logic [127:0] rk_sel;

  // code 3 runs as a 256-bit key
  always_comb begin
    case (key_length)
      KEY_LEN_128: nk = 4'd4;
      KEY_LEN_192: nk = 4'd6;
      default:     nk = 4'd8;
    endcase
  end
  assign nk_m1    = 3'(nk - 4'd1);
  assign total_m1 = 6'((6'(nk) + 6'd7) * 6'd4 - 6'd1);
  assign nr       = nk + 4'd6;

  assign status.cfg_hit = cfg_valid && (cfg_index <= REG_KEY_WORD_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length  <= KEY_LEN_256;
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length  <= cfg_data[1:0];
        REG_KEY_WORD_0: key_word[0] <= cfg_data;
        REG_KEY_WORD_1: key_word[1] <= cfg_data;
        REG_KEY_WORD_2: key_word[2] <= cfg_data;
        REG_KEY_WORD_3: key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // one schedule word per cycle; win[0] is the newest word, win[nk-1] is w[i-nk]
  always_comb begin
    src = key_word[exp_idx[2:1]];
    if (exp_mod == 3'd0) begin
      t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h000000};
    end else if (nk == 4'd8 && exp_mod == 3'd4) begin
      t = sub_word(win[0]);
    end else begin
      t = win[0];
    end
    if (exp_idx < 6'(nk)) new_word = exp_idx[0] ? src[31:0] : src[63:32];
    else                  new_word = win[nk_m1] ^ t;
  end

  assign status.exp_last = (exp_idx == total_m1);

  always_ff @(posedge clk) begin
    if (rst || cmd.exp_clear) begin
      exp_idx <= '0;
      exp_mod <= '0;
      rcon    <= 8'h01;
    end else if (cmd.exp_step) begin
      exp_idx <= exp_idx + 6'd1;
      exp_mod <= (exp_mod == nk_m1) ? 3'd0 : exp_mod + 3'd1;
      if (exp_idx >= 6'(nk) && exp_mod == 3'd0) rcon <= xtime(rcon);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step && !cmd.exp_clear) begin
      for (int k = 7; k > 0; k--) win[k] <= win[k - 1];
      win[0] <= new_word;
      case (exp_idx[1:0])
        2'd0:    rk_row[exp_idx[5:2]][127:96] <= new_word;
        2'd1:    rk_row[exp_idx[5:2]][95:64]  <= new_word;
        2'd2:    rk_row[exp_idx[5:2]][63:32]  <= new_word;
        default: rk_row[exp_idx[5:2]][31:0]   <= new_word;
      endcase
    end
  end

  // single read port on the round-key rows
  assign rk_addr = cmd.load ? (func ? nr : 4'd0) : rnd;
  assign rk_sel  = rk_row[rk_addr];

  assign status.round_last = dir ? (rnd == 4'd0) : (rnd == nr);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st  <= {block_high, block_low} ^ rk_sel;
      dir <= func;
      rnd <= func ? nr - 4'd1 : 4'd1;
    end else if (cmd.round_step) begin
      if (dir) begin
        st  <= dec_round(st, rk_sel, rnd != 4'd0);
        rnd <= rnd - 4'd1;
      end else begin
        st  <= enc_round(st, rk_sel, rnd != nr);
        rnd <= rnd + 4'd1;
      end
    end
  end

  assign out_high = st[127:64];
  assign out_low  = st[63:0];

endmodule

// ===== hdl/aes_block_cipher_core.sv =====
// Top level of the AES-128/192/256 block cipher core.
// Depends on aes_pkg, aes_ctrl, aes_datapath and aes_block_cipher_core_defines.svh.
//
// Usage:
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready is
//   always high. Index 0 is the key length code, 1..4 the four 64-bit key words.
//   Each register write beat restarts key expansion; write only while idle.
//   Block channel: a beat is taken when start is high, busy is low and no key
//   write comes; func selects encrypt (0) or decrypt (1), block_high/low carry it.
//   Result: out_high/out_low are valid for the single cycle that done is high.
//   The receiver cannot stall, so there is no backpressure on results.
// Operation:
//   Key expansion builds one 32-bit schedule word per cycle: 44, 52 or 60 words
//   for 128, 192 or 256-bit keys, after reset and after each key write.
//   The first key add happens at the accept edge, then Nr rounds (10, 12 or 14)
//   run one per cycle through the shared round unit. done follows the last round;
//   busy drops the cycle after done, so a new block is taken only once the
//   previous block's result beat is out.
// Reset: rst is synchronous, active high; it loads the 256-bit all-zero key
//   and starts expansion, with busy high until the schedule is built.
`include "aes_block_cipher_core_defines.svh"
module aes_block_cipher_core import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        done,
  output logic [63:0] out_high,
  output logic [63:0] out_low
);

  aes_cmd_t    cmd;
  aes_status_t status;

  // config writes are taken every cycle; the user must keep them to idle time, as the block does not enforce it
  assign cfg_ready = 1'b1;

  aes_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  aes_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .block_high (block_high),
    .block_low  (block_low),
    .cmd        (cmd),
    .status     (status),
    .out_high   (out_high),
    .out_low    (out_low)
  );

  // an accepted block keeps the core busy until its result beat
  `AES_ASSERT_IMPL(a_start_busy, (start && !busy && !cfg_valid) |=> busy)
  // a result beat lasts exactly one cycle
  `AES_ASSERT_IMPL(a_done_single, done |=> !done)
  // done only ever shows while the core reports busy
  `AES_ASSERT_NEVER(a_done_idle, done && !busy)

endmodule
